// ===== hdl/slws_pkg.sv =====
`timescale 1ns / 1ps
package slws_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SUM_W    = 32 + $clog2(CAPACITY);
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_DUMP   = 1'b1
	} cmd_t;

	typedef struct packed {
		logic               command;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic               last;
		logic [6:0]         count;
		logic signed [31:0] minimum;
		logic signed [31:0] maximum;
		logic signed [31:0] mean;
		logic               full_drop;
	} out_item_t;

	typedef struct packed {
		cmd_t               op;
		logic signed [31:0] value;
	} op_item_t;

	typedef struct packed {
		logic               start;
		logic [SUM_W-1:0]   dividend;
		logic [CNT_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [SUM_W-1:0]   quotient;
	} div_rsp_t;

endpackage

// ===== hdl/sorted_list_with_stats.sv =====
// Insert: the result is registered once the bit-serial mean divider has finished (an
// insert into a full list is dropped and reported without division).
// Dump of n held values: n results, one per cycle when not stalled.
// One item is worked on at a time; a two-entry queue takes items meanwhile.
// Reset (arst_n low, asynchronous) empties the list and clears sum and statistics;
// stored values need no clearing.
`timescale 1ns / 1ps
module sorted_list_with_stats import slws_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	logic     q_valid, q_take;
	op_item_t q_item;

	slws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_item    (q_item)
	);

	slws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_item    (q_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.full_drop |-> rsp.count == 7'(CAPACITY) && rsp.last)
		else $error("drop reported while not full");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.count <= 7'(CAPACITY))
		else $error("count beyond capacity");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.count == '0 |-> rsp.last && rsp.mean == '0 && rsp.minimum == '0)
		else $error("empty list reports nonzero stats");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.full_drop |-> rsp.minimum <= rsp.maximum)
		else $error("minimum above maximum");

endmodule

// ===== hdl/slws_front.sv =====
`timescale 1ns / 1ps
module slws_front import slws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  in_item_t req,
	output logic     q_valid,
	input  logic     q_take,
	output op_item_t q_item
);

	op_item_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]      fill_q;
	logic                 push, pop;

	assign req_stall = (fill_q == (QPTR_W+1)'(QDEPTH));
	assign push      = req_valid && !req_stall;
	assign q_valid   = (fill_q != '0);
	assign pop       = q_valid && q_take;
	assign q_item    = slot_q[rd_ptr_q];

	// classify and hold incoming items
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].op    <= req.command ? CMD_DUMP : CMD_INSERT;
			slot_q[wr_ptr_q].value <= req.value;
		end
	end

	// advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hdl/slws_div.sv =====
`timescale 1ns / 1ps
module slws_div import slws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t dreq,
	output div_rsp_t drsp
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  num_q;
	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q, done_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	// one restoring step: bring down next bit, subtract if it fits
	assign trial = {rem_q[CNT_W-1:0], num_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (dreq.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dreq.start) begin
			num_q <= dreq.dividend;
			den_q <= dreq.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			num_q <= {num_q[SUM_W-2:0], fits};
		end
	end

	assign drsp.done     = done_q;
	assign drsp.quotient = num_q;

endmodule

// ===== hdl/slws_back.sv =====
`timescale 1ns / 1ps
module slws_back import slws_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_take,
	input  op_item_t  q_item,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_RESP = 4'b0100,
		ST_DUMP = 4'b1000
	} state_t;

	state_t                   state_q;
	logic signed [31:0]       cell_q [CAPACITY];
	logic [CAPACITY-1:0]      gt;
	logic [CNT_W-1:0]         count_q, idx_q;
	logic signed [SUM_W-1:0]  sum_q, sum_next;
	logic signed [31:0]       min_q, max_q, mean_q, value;
	logic                     neg_q;
	logic                     full, do_insert, do_rotate, dump_last, emit_dump;
	div_req_t                 dreq;
	div_rsp_t                 drsp;
	logic [SUM_W-1:0]         mean_mag;
	out_item_t                out_q;
	logic                     out_valid_q;

	assign value     = q_item.value;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign q_take    = (state_q == ST_IDLE) && q_valid;
	assign do_insert = q_take && (q_item.op == CMD_INSERT) && !full;
	assign sum_next  = sum_q + SUM_W'(value);
	assign emit_dump = (state_q == ST_DUMP) && (!out_valid_q || !rsp_stall);
	assign do_rotate = emit_dump;
	assign dump_last = (idx_q == count_q - 1'b1);

	// compare against every held cell
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt[i] = (CNT_W'(i) < count_q) && (cell_q[i] > value);
		end
	end

	// insertion chain: shift larger values up, drop value in place;
	// dump rotates the held part left by one
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			always_ff @(posedge clk) begin
				if (do_insert) begin
					if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
						cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
					end else if (gt[i] || CNT_W'(i) == count_q) begin
						cell_q[i] <= value;
					end
				end else if (do_rotate) begin
					if (CNT_W'(i) == count_q - 1'b1 || i == CAPACITY - 1) begin
						cell_q[i] <= cell_q[0];
					end else begin
						cell_q[i] <= cell_q[(i < CAPACITY - 1) ? i + 1 : 0];
					end
				end
			end
		end
	endgenerate

	// start mean division on the magnitude of the new sum
	assign dreq.start    = do_insert;
	assign dreq.dividend = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
	assign dreq.divisor  = count_q + 1'b1;

	slws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.dreq   (dreq),
		.drsp   (drsp)
	);

	assign mean_mag = neg_q ? SUM_W'(-drsp.quotient) : drsp.quotient;

	// sequence control, statistics and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			min_q       <= '0;
			max_q       <= '0;
			mean_q      <= '0;
			neg_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					out_valid_q <= 1'b0;
					if (q_take) begin
						out_q.element   <= '0;
						out_q.last      <= 1'b1;
						out_q.count     <= 7'(count_q);
						out_q.minimum   <= min_q;
						out_q.maximum   <= max_q;
						out_q.mean      <= mean_q;
						out_q.full_drop <= 1'b0;
						if (q_item.op == CMD_INSERT) begin
							if (full) begin
								out_q.full_drop <= 1'b1;
								out_valid_q     <= 1'b1;
								state_q         <= ST_RESP;
							end else begin
								count_q <= count_q + 1'b1;
								sum_q   <= sum_next;
								neg_q   <= sum_next[SUM_W-1];
								min_q   <= (count_q == '0 || value < min_q) ? value : min_q;
								max_q   <= (count_q == '0 || value >= max_q) ? value : max_q;
								state_q <= ST_DIV;
							end
						end else if (count_q == '0) begin
							out_valid_q <= 1'b1;
							state_q     <= ST_RESP;
						end else begin
							idx_q   <= '0;
							state_q <= ST_DUMP;
						end
					end
				end
				ST_DIV: begin
					if (drsp.done) begin
						mean_q      <= mean_mag[31:0];
						out_q.count <= 7'(count_q);
						out_q.minimum <= min_q;
						out_q.maximum <= max_q;
						out_q.mean  <= mean_mag[31:0];
						out_valid_q <= 1'b1;
						state_q     <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!rsp_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_DUMP: begin
					if (emit_dump) begin
						out_q.element <= cell_q[0];
						out_q.last    <= dump_last;
						out_valid_q   <= 1'b1;
						idx_q         <= idx_q + 1'b1;
						if (dump_last) state_q <= ST_RESP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
